/* sv/bsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the MSB-first bit stream packer.
// ----------------------------------------------------------------------------
package bsp_pkg;

	localparam int BUFFER_WORDS_DEF = 1024;
	localparam int ACC_W            = 64;
	localparam int WORD_W           = 32;
	localparam int BYTE_W           = 8;
	localparam int CNT_W            = 6;
	localparam int PAD_W            = 13;
	localparam int ADDR_W           = 10;
	localparam int TOTAL_W          = 16;
	localparam int IN_DATA_W        = 56;
	localparam int IN_USER_W        = 2;
	localparam int OUT_DATA_W       = 56;
	localparam int OUT_USER_W       = 3;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_ALIGN = 2'd1,
		OP_FLUSH = 2'd2,
		OP_PAD   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADCOUNT = 2'd1,
		ST_PADSMALL = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [WORD_W-1:0]  value;
		logic [CNT_W-1:0]   bit_count;
		logic [PAD_W-1:0]   pad_bytes;
	} item_t;

	typedef struct packed {
		logic               word_valid;
		logic [WORD_W-1:0]  out_word;
		logic [ADDR_W-1:0]  word_address;
		logic [PAD_W-1:0]   byte_count;
		status_t            status;
	} result_t;

endpackage

/* sv/bsp_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_in_stage
// Input register: unpacks the stream item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module bsp_in_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bsp_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [bsp_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                           advance,
	output logic                           item_valid,
	output bsp_pkg::item_t                 item
);
	import bsp_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	assign s_tready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.opcode    <= opcode_t'(s_tuser);
			item_s1.value     <= s_tdata[WORD_W-1:0];
			item_s1.bit_count <= s_tdata[WORD_W+CNT_W-1:WORD_W];
			item_s1.pad_bytes <= s_tdata[WORD_W+CNT_W+PAD_W-1:WORD_W+CNT_W];
		end
	end

endmodule

/* sv/bsp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_core
// Packing state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module bsp_core #(
	parameter int BUFFER_WORDS = bsp_pkg::BUFFER_WORDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  bsp_pkg::item_t   item,
	output bsp_pkg::result_t result
);
	import bsp_pkg::*;

	localparam int NW_W = $clog2(BUFFER_WORDS + 1);

	logic [ACC_W-1:0]   acc_q, acc_nx, acc_put;
	logic [CNT_W-1:0]   pend_q, pend_nx;
	logic [NW_W-1:0]    next_q, next_nx;
	logic [TOTAL_W-1:0] total_q, total_nx;

	logic [CNT_W-1:0]   put_cnt;
	logic [WORD_W-1:0]  put_val;
	logic               bad_cnt;
	logic               put_en;
	logic [6:0]         shift_amt;
	logic [6:0]         pend_sum;
	logic               full;
	logic               room;
	logic               has_pend;
	logic               flush_ovf;
	logic [TOTAL_W-1:0] target;
	logic [16:0]        words_sum;
	logic [11:0]        words;
	logic [31:0]        next_ext;
	logic [16:0]        byte_sum;
	logic               want_bytes;
	result_t            res;

	assign bad_cnt  = (item.bit_count == '0) || (item.bit_count > CNT_W'(WORD_W));
	assign next_ext = 32'(next_q);
	assign room     = next_ext < 32'(BUFFER_WORDS);
	assign has_pend = pend_q != '0;
	assign flush_ovf = has_pend && !room;

	always_comb begin
		put_cnt = item.bit_count;
		put_val = item.value & (32'hFFFF_FFFF >> (CNT_W'(WORD_W) - item.bit_count));
		put_en  = !bad_cnt;
		if (item.opcode == OP_ALIGN) begin
			put_cnt = CNT_W'(BYTE_W) - {3'b000, pend_q[2:0]};
			put_val = '0;
			put_en  = pend_q[2:0] != 3'd0;
		end
	end

	assign shift_amt = 7'd64 - {1'b0, put_cnt} - {1'b0, pend_q};
	assign acc_put   = acc_q | ({32'b0, put_val} << shift_amt);
	assign pend_sum  = {1'b0, pend_q} + {1'b0, put_cnt};
	assign full      = pend_sum >= 7'd32;

	assign target    = {item.pad_bytes, 3'b000};
	assign words_sum = {1'b0, target} + 17'd31;
	assign words     = words_sum[16:5];

	always_comb begin
		acc_nx     = acc_q;
		pend_nx    = pend_q;
		next_nx    = next_q;
		total_nx   = total_q;
		res        = '0;
		res.status = ST_OK;
		want_bytes = 1'b0;
		case (item.opcode)
			OP_WRITE, OP_ALIGN: begin
				if (item.opcode == OP_WRITE && bad_cnt) begin
					res.status = ST_BADCOUNT;
				end else if (put_en) begin
					if (full && !room) begin
						res.status = ST_OVERFLOW;
					end else begin
						if (full) begin
							res.word_valid   = 1'b1;
							res.out_word     = acc_put[63:32];
							res.word_address = next_ext[ADDR_W-1:0];
							acc_nx           = {acc_put[31:0], 32'b0};
							pend_nx          = CNT_W'(pend_sum - 7'd32);
							next_nx          = next_q + NW_W'(1);
						end else begin
							acc_nx  = acc_put;
							pend_nx = pend_sum[CNT_W-1:0];
						end
						total_nx = total_q + TOTAL_W'(put_cnt);
					end
				end
			end
			OP_FLUSH, OP_PAD: begin
				want_bytes = 1'b1;
				if (flush_ovf) begin
					res.status = ST_OVERFLOW;
				end else begin
					if (has_pend) begin
						res.word_valid   = 1'b1;
						res.out_word     = acc_q[63:32];
						res.word_address = next_ext[ADDR_W-1:0];
						acc_nx           = '0;
						pend_nx          = '0;
						next_nx          = next_q + NW_W'(1);
					end
					if (item.opcode == OP_PAD) begin
						if (target < total_q) begin
							res.status = ST_PADSMALL;
						end else if (32'(words) > 32'(BUFFER_WORDS)) begin
							res.status = ST_OVERFLOW;
						end else begin
							total_nx = target;
							next_nx  = NW_W'(words);
						end
					end
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

	assign byte_sum = {1'b0, total_nx} + 17'd7;

	always_comb begin
		result            = res;
		result.byte_count = want_bytes ? byte_sum[15:3] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			pend_q  <= '0;
			next_q  <= '0;
			total_q <= '0;
		end else if (advance) begin
			acc_q   <= acc_nx;
			pend_q  <= pend_nx;
			next_q  <= next_nx;
			total_q <= total_nx;
		end
	end

endmodule

/* sv/bsp_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_out_stage
// Result register: holds one result item and packs it onto the master side.
// ----------------------------------------------------------------------------
module bsp_out_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  bsp_pkg::result_t                result,
	output logic                            load_ready,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bsp_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [bsp_pkg::OUT_USER_W-1:0]  m_tuser
);
	import bsp_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign load_ready = !valid_s2 || m_tready;
	assign m_tvalid   = valid_s2;
	assign m_tdata    = {1'b0, res_s2.byte_count, res_s2.word_address, res_s2.out_word};
	assign m_tuser    = {res_s2.status, res_s2.word_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ready) begin
			res_s2 <= result;
		end
	end

endmodule

/* sv/bit_stream_packer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_stream_packer_unit
// MSB-first variable-width bit packer emitting 32-bit words with addresses.
// ----------------------------------------------------------------------------
// Takes one item per clock when the output is not stalled and returns exactly
// one result item for each. Each item passes an input register, one pass of
// the 64-bit shift-or and word-emit logic that also updates the packing state,
// and a result register; that shift-or path sets the clock rate. Ops on
// s_tuser: write bits, align to byte, flush a partial word, pad to a byte size
// (flush and pad return the rounded byte count).
module bit_stream_packer_unit #(
	parameter int BUFFER_WORDS = bsp_pkg::BUFFER_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// value[31:0], bit_count[37:32], pad_bytes[50:38], zero fill
	input  logic [bsp_pkg::IN_DATA_W-1:0]   s_tdata,
	// opcode[1:0]
	input  logic [bsp_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_word[31:0], word_address[41:32], byte_count[54:42], zero fill
	output logic [bsp_pkg::OUT_DATA_W-1:0]  m_tdata,
	// word_valid[0], status[2:1]
	output logic [bsp_pkg::OUT_USER_W-1:0]  m_tuser
);
	import bsp_pkg::*;

	logic    item_valid;
	logic    load_ready;
	logic    advance;
	item_t   item;
	result_t result;

	assign advance = item_valid && load_ready;

	bsp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	bsp_core #(
		.BUFFER_WORDS (BUFFER_WORDS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item),
		.result  (result)
	);

	bsp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.result     (result),
		.load_ready (load_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
